// ----- rtl/magnetic_tape_offset_estimator_defines.svh -----
// ----------------------------------------------------------------------------
// magnetic tape offset estimator assertion macros
// shared concurrent assertion forms, clocked on clk_i, quiet during reset
// ----------------------------------------------------------------------------
`ifndef MAGNETIC_TAPE_OFFSET_ESTIMATOR_DEFINES_SVH
`define MAGNETIC_TAPE_OFFSET_ESTIMATOR_DEFINES_SVH

// same-cycle implication
`define MTO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mto_pkg.sv -----
// ----------------------------------------------------------------------------
// mto_pkg
// shared widths, codes, command types and sizing functions of the estimator
// ----------------------------------------------------------------------------
package mto_pkg;

  localparam int SENSOR_W   = 16;
  localparam int OFFSET_W   = 14;
  localparam int OOT_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int SCAN_MAX   = 16;

  localparam int NUM_SENSORS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_FORWARD        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_FORWARD        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_TRACK_OFFSET = 2'd2;

  localparam logic [OOT_W-1:0] OOT_RESET = 13'd1280;

  // kept sign codes
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  typedef struct packed {
    logic load;
    logic scan;
    logic div_init;
    logic div_step;
    logic write_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
  } dp_status_t;

  // sensors actually looked at
  function automatic int scan_count(input int n);
    return (n < SCAN_MAX) ? n : SCAN_MAX;
  endfunction

  // signed width of the distance sum in half pitches
  function automatic int hs_width(input int n);
    return $clog2(scan_count(n) * (n - 1) + 1) + 1;
  endfunction

  // width of the scaled dividend magnitude
  function automatic int mag_width(input int n, input int f);
    return hs_width(n) - 1 + f - 1;
  endfunction

  // width of the active sensor count
  function automatic int count_width(input int n);
    return $clog2(scan_count(n) + 1);
  endfunction

  // width of the controller step counter
  function automatic int step_width(input int n, input int f);
    return $clog2((scan_count(n) > mag_width(n, f)) ? scan_count(n) : mag_width(n, f));
  endfunction

endpackage

// ----- rtl/mto_in_if.sv -----
// ----------------------------------------------------------------------------
// mto_in_if
// sensor bar reading channel: valid, ready and the reading
// ----------------------------------------------------------------------------
interface mto_in_if;
  logic                          valid;
  logic                          ready;
  logic                          bar_select;
  logic [mto_pkg::SENSOR_W-1:0]  sensor_bits;

  modport source (output valid, bar_select, sensor_bits, input ready);
  modport sink   (input valid, bar_select, sensor_bits, output ready);
endinterface

// ----- rtl/mto_out_if.sv -----
// ----------------------------------------------------------------------------
// mto_out_if
// offset result channel: valid, ready and the result
// ----------------------------------------------------------------------------
interface mto_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mto_pkg::OFFSET_W-1:0] offset_y;
  logic                                on_track;
  logic                                bar_echo;
  logic                                acquired;

  modport source (output valid, offset_y, on_track, bar_echo, acquired, input ready);
  modport sink   (input valid, offset_y, on_track, bar_echo, acquired, output ready);
endinterface

// ----- rtl/mto_cfg_if.sv -----
// ----------------------------------------------------------------------------
// mto_cfg_if
// configuration write channel: valid, ready, register index and data
// ----------------------------------------------------------------------------
interface mto_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mto_pkg::CFG_IDX_W-1:0]  index;
  logic [mto_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/mto_ctrl.sv -----
// ----------------------------------------------------------------------------
// mto_ctrl
// sequencer: sensor scan, divide steps and result hand-off
// ----------------------------------------------------------------------------
`include "magnetic_tape_offset_estimator_defines.svh"

module mto_ctrl #(
  parameter int NUM_SENSORS = mto_pkg::NUM_SENSORS_DEF,
  parameter int FRAC_BITS   = mto_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  mto_pkg::dp_status_t status_i,
  output mto_pkg::ctrl_cmd_t  cmd_o
);
  import mto_pkg::*;

  localparam int SCAN_N = scan_count(NUM_SENSORS);
  localparam int MAG_W  = mag_width(NUM_SENSORS, FRAC_BITS);
  localparam int STEP_W = step_width(NUM_SENSORS, FRAC_BITS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_PREP   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan      = (state_q == S_SCAN);
    cmd_o.div_init  = (state_q == S_PREP) && !status_i.count_zero;
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.write_out = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SCAN;
          step_d  = STEP_W'(SCAN_N - 1);
        end
      end
      S_SCAN: begin
        if (step_q == '0) begin
          state_d = S_PREP;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_PREP: begin
        // no active sensor skips the divide
        if (status_i.count_zero) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_DIV;
          step_d  = STEP_W'(MAG_W - 1);
        end
      end
      S_DIV: begin
        if (step_q == '0) begin
          state_d = S_FINISH;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_FINISH: begin
        if (cmd_o.write_out) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  `MTO_ASSERT_NXT(a_result_held, out_valid_q && !out_ready_i, out_valid_q, "result dropped while stalled")
  `MTO_ASSERT_NXT(a_scan_start, cmd_o.load, (state_q == S_SCAN) && (step_q == STEP_W'(SCAN_N - 1)), "scan did not start")
  `MTO_ASSERT_NXT(a_div_end, (state_q == S_DIV) && (step_q == '0), state_q == S_FINISH, "divide overran")
  `MTO_ASSERT_NXT(a_write_done, cmd_o.write_out, out_valid_q && (state_q == S_IDLE), "result not presented")

endmodule

// ----- rtl/mto_dpath.sv -----
// ----------------------------------------------------------------------------
// mto_dpath
// config registers, distance accumulator, restoring divider, result register
// ----------------------------------------------------------------------------
module mto_dpath #(
  parameter int NUM_SENSORS = mto_pkg::NUM_SENSORS_DEF,
  parameter int FRAC_BITS   = mto_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  mto_cfg_if.sink                             cfg_i,
  input  logic                                bar_select_i,
  input  logic [mto_pkg::SENSOR_W-1:0]        sensor_bits_i,
  input  mto_pkg::ctrl_cmd_t                  cmd_i,
  output mto_pkg::dp_status_t                 status_o,
  output logic signed [mto_pkg::OFFSET_W-1:0] offset_y_o,
  output logic                                on_track_o,
  output logic                                bar_echo_o,
  output logic                                acquired_o
);
  import mto_pkg::*;

  localparam int HS_W  = hs_width(NUM_SENSORS);
  localparam int MAG_W = mag_width(NUM_SENSORS, FRAC_BITS);
  localparam int CNT_W = count_width(NUM_SENSORS);
  localparam int EXT_W = MAG_W + OFFSET_W + 1;

  localparam logic signed [HS_W-1:0] TERM_START = HS_W'(NUM_SENSORS - 1);
  localparam logic signed [HS_W-1:0] TERM_STEP  = HS_W'(2);
  localparam logic [OFFSET_W-1:0] OFF_MAX = {1'b0, {(OFFSET_W-1){1'b1}}};
  localparam logic [OFFSET_W-1:0] OFF_MIN = {1'b1, {(OFFSET_W-1){1'b0}}};

  // configuration
  logic             head_fwd_q;
  logic             tail_fwd_q;
  logic [OOT_W-1:0] oot_q;

  // persistent tracking state
  logic [1:0] last_sign_q;
  logic       ever_found_q;

  // per-item working registers
  logic [SENSOR_W-1:0]    bits_q;
  logic                   bar_q;
  logic signed [HS_W-1:0] term_q;
  logic signed [HS_W-1:0] sum_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [MAG_W-1:0]       nq_q;
  logic [CNT_W-1:0]       rem_q;
  logic                   neg_q;
  logic [1:0]             res_sign_q;

  // result register
  logic [OFFSET_W-1:0] offset_q;
  logic                on_q;
  logic                bar_out_q;
  logic                acq_q;

  logic                   fwd;
  logic                   sum_neg;
  logic [HS_W-1:0]        sum_abs;
  logic [CNT_W:0]         trial;
  logic                   trial_ge;
  logic [CNT_W:0]         trial_sub;
  logic [EXT_W-1:0]       q_ext;
  logic [OFFSET_W-1:0]    offset_on;
  logic [OFFSET_W-1:0]    offset_off;
  logic [OFFSET_W-1:0]    oot_ext;

  assign cfg_i.ready         = 1'b1;
  assign status_o.count_zero = (cnt_q == '0);

  assign fwd     = bar_q ? tail_fwd_q : head_fwd_q;
  assign sum_neg = sum_q[HS_W-1];
  assign sum_abs = sum_neg ? HS_W'(-sum_q) : HS_W'(sum_q);

  assign trial     = {rem_q, nq_q[MAG_W-1]};
  assign trial_ge  = (trial >= {1'b0, cnt_q});
  assign trial_sub = trial - {1'b0, cnt_q};

  // truncated quotient magnitude, sign applied after the divide
  assign q_ext = EXT_W'(nq_q);
  always_comb begin
    if (neg_q) begin
      offset_on = (q_ext > EXT_W'(OFF_MIN)) ? OFF_MIN : -q_ext[OFFSET_W-1:0];
    end else begin
      offset_on = (q_ext > EXT_W'(OFF_MAX)) ? OFF_MAX : q_ext[OFFSET_W-1:0];
    end
  end

  assign oot_ext = {1'b0, oot_q};
  always_comb begin
    case (last_sign_q)
      SIGN_POS: offset_off = oot_ext;
      SIGN_NEG: offset_off = -oot_ext;
      default:  offset_off = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_fwd_q <= 1'b1;
      tail_fwd_q <= 1'b1;
      oot_q      <= OOT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_HEAD_FORWARD:        head_fwd_q <= cfg_i.data[0];
        REG_TAIL_FORWARD:        tail_fwd_q <= cfg_i.data[0];
        REG_OUT_OF_TRACK_OFFSET: oot_q      <= cfg_i.data[OOT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sign_q  <= SIGN_ZERO;
      ever_found_q <= 1'b0;
    end else if (cmd_i.write_out && (cnt_q != '0)) begin
      last_sign_q  <= res_sign_q;
      ever_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bits_q <= sensor_bits_i;
      bar_q  <= bar_select_i;
      term_q <= TERM_START;
      sum_q  <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.scan) begin
      // one sensor per cycle, distance steps down by two half pitches
      bits_q <= {1'b0, bits_q[SENSOR_W-1:1]};
      term_q <= term_q - TERM_STEP;
      if (bits_q[0]) begin
        sum_q <= sum_q + term_q;
        cnt_q <= cnt_q + 1'b1;
      end
    end
    if (cmd_i.div_init) begin
      nq_q  <= {sum_abs[HS_W-2:0], {(FRAC_BITS-1){1'b0}}};
      rem_q <= '0;
      neg_q <= sum_neg ^ fwd;
      if (sum_q == '0) begin
        res_sign_q <= SIGN_ZERO;
      end else begin
        res_sign_q <= (sum_neg ^ fwd) ? SIGN_NEG : SIGN_POS;
      end
    end
    if (cmd_i.div_step) begin
      nq_q  <= {nq_q[MAG_W-2:0], trial_ge};
      rem_q <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
    if (cmd_i.write_out) begin
      offset_q  <= (cnt_q != '0) ? offset_on : offset_off;
      on_q      <= (cnt_q != '0);
      bar_out_q <= bar_q;
      acq_q     <= ever_found_q | (cnt_q != '0);
    end
  end

  assign offset_y_o = $signed(offset_q);
  assign on_track_o = on_q;
  assign bar_echo_o = bar_out_q;
  assign acquired_o = acq_q;

endmodule

// ----- rtl/magnetic_tape_offset_estimator.sv -----
// ----------------------------------------------------------------------------
// magnetic_tape_offset_estimator
// lateral tape offset from one sensor bar reading per transaction
// ----------------------------------------------------------------------------
// usage:
//   in_i   takes one reading: bar_select (0 head, 1 tail) and sensor_bits
//   out_o  gives one result per reading: offset_y (signed, Q8 pitches),
//          on_track, bar_echo and acquired
//   cfg_i  writes head_forward (0), tail_forward (1), out_of_track_offset (2);
//          always ready, write only while no reading is in flight
// timing:
//   one reading at a time; the sensor scan looks at min(NUM_SENSORS,16) sensors,
//   one per cycle, then the restoring divide by the active count takes one
//   quotient bit per cycle (15 bits at the defaults), with the IDLE, PREP and
//   FINISH states around them; the divide is skipped when off track
//   the result sits in an output register, so one result may wait there
//   while the next reading is worked on; a stalled receiver only holds the
//   next result back once that register is full
// reset:
//   forward settings to 1, out-of-track offset to 1280, kept sign to zero,
//   acquired history cleared, result register not reset; no clearing pass
// ----------------------------------------------------------------------------
module magnetic_tape_offset_estimator #(
  parameter int NUM_SENSORS = mto_pkg::NUM_SENSORS_DEF,
  parameter int FRAC_BITS   = mto_pkg::FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mto_in_if.sink   in_i,
  mto_out_if.source out_o,
  mto_cfg_if.sink  cfg_i
);
  import mto_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mto_ctrl #(
    .NUM_SENSORS (NUM_SENSORS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mto_dpath #(
    .NUM_SENSORS (NUM_SENSORS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_i),
    .bar_select_i  (in_i.bar_select),
    .sensor_bits_i (in_i.sensor_bits),
    .cmd_i         (cmd),
    .status_o      (status),
    .offset_y_o    (out_o.offset_y),
    .on_track_o    (out_o.on_track),
    .bar_echo_o    (out_o.bar_echo),
    .acquired_o    (out_o.acquired)
  );

endmodule
